// File: rtl/mhpq_pkg.sv
// Package for the binary min-heap priority queue.
// Holds the request/status codes, entry and result types, stream field layout
// and the sequencer state type. No dependencies.
`timescale 1ns / 1ps

package mhpq_pkg;

    localparam int HEAP_DEPTH_DEF = 1024;

    // Stream layout
    localparam int S_TDATA_W = 128;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 144;  // 139 bits of fields, padded to bytes
    localparam int M_TUSER_W = 2;
    localparam int COUNT_W   = 11;

    typedef enum logic [1:0] {
        REQ_INSERT  = 2'd0,
        REQ_EXTRACT = 2'd1,
        REQ_CLEAR   = 2'd2,
        REQ_UNUSED  = 2'd3
    } mhpq_req_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } mhpq_status_t;

    typedef struct packed {
        logic [31:0]        trace;
        logic [31:0]        parent;
        logic [31:0]        item;
        logic signed [31:0] key;
    } mhpq_entry_t;

    typedef struct packed {
        mhpq_status_t       status;
        logic [COUNT_W-1:0] count;
        mhpq_entry_t        ent;
    } mhpq_result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_CHK,
        ST_INS_CMP,
        ST_EXT_LD,
        ST_EXT_CHK,
        ST_EXT_CMP,
        ST_RESP
    } mhpq_state_t;

endpackage

// File: rtl/mhpq_mem.sv
// Heap entry store: one write port, two read ports, registered read data.
// Depends on mhpq_pkg for the entry type.
`timescale 1ns / 1ps

module mhpq_mem #(
    parameter int DEPTH = mhpq_pkg::HEAP_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                 aclk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  mhpq_pkg::mhpq_entry_t wdata,
    input  logic [AW-1:0]        raddr_a,
    input  logic [AW-1:0]        raddr_b,
    output mhpq_pkg::mhpq_entry_t rdata_a,
    output mhpq_pkg::mhpq_entry_t rdata_b
);

    mhpq_pkg::mhpq_entry_t mem [DEPTH];
    mhpq_pkg::mhpq_entry_t rdata_a_reg;
    mhpq_pkg::mhpq_entry_t rdata_b_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// File: rtl/mhpq_ctrl.sv
// Heap sequencer: entry count, sift-up for insert, sift-down for extract.
// Drives the entry store (mhpq_mem); depends on mhpq_pkg.
`timescale 1ns / 1ps

module mhpq_ctrl #(
    parameter int HEAP_DEPTH = mhpq_pkg::HEAP_DEPTH_DEF,
    parameter int AW         = $clog2(HEAP_DEPTH),
    parameter int CW         = $clog2(HEAP_DEPTH + 1)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // request
    input  logic                  req_valid,
    output logic                  req_ready,
    input  mhpq_pkg::mhpq_req_t   req_type,
    input  mhpq_pkg::mhpq_entry_t req_ent,
    // result
    output logic                  res_valid,
    input  logic                  res_take,
    output mhpq_pkg::mhpq_result_t res,
    // entry store
    output logic                  mem_we,
    output logic [AW-1:0]         mem_waddr,
    output mhpq_pkg::mhpq_entry_t mem_wdata,
    output logic [AW-1:0]         mem_raddr_a,
    output logic [AW-1:0]         mem_raddr_b,
    input  mhpq_pkg::mhpq_entry_t mem_rdata_a,
    input  mhpq_pkg::mhpq_entry_t mem_rdata_b
);

    localparam logic [CW-1:0] DEPTH_C = CW'(HEAP_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    mhpq_pkg::mhpq_state_t  state_reg, state_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [CW-1:0]          pos_reg, pos_next;     // 1-based heap position
    mhpq_pkg::mhpq_entry_t  ent_reg, ent_next;     // entry being sifted
    mhpq_pkg::mhpq_status_t stat_reg, stat_next;
    mhpq_pkg::mhpq_entry_t  out_reg, out_next;     // extracted root

    logic                   accept;
    logic [CW-1:0]          pos_m1;
    logic [CW-1:0]          up_pos;
    logic [CW:0]            child_pos;             // left child, one bit wider
    logic [CW:0]            count_x;
    logic                   has_right;
    logic                   pick_right;
    mhpq_pkg::mhpq_entry_t  child_ent;
    logic [CW-1:0]          child_sel;
    logic [CW+10:0]         count_wide;

    assign accept     = req_valid && (state_reg == mhpq_pkg::ST_IDLE);
    assign pos_m1     = pos_reg - ONE_C;
    assign up_pos     = pos_reg >> 1;
    assign child_pos  = {pos_reg, 1'b0};
    assign count_x    = {1'b0, count_reg};
    assign has_right  = child_pos < count_x;
    assign pick_right = has_right && (mem_rdata_b.key < mem_rdata_a.key);
    assign child_ent  = pick_right ? mem_rdata_b : mem_rdata_a;
    assign child_sel  = pick_right ? CW'(child_pos + 1'b1) : CW'(child_pos);
    assign count_wide = {11'b0, count_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mhpq_pkg::ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
        pos_reg  <= pos_next;
        ent_reg  <= ent_next;
        stat_reg <= stat_next;
        out_reg  <= out_next;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mhpq_pkg::ST_IDLE: begin
                if (accept) begin
                    unique case (req_type)
                        mhpq_pkg::REQ_INSERT:
                            state_next = (count_reg >= DEPTH_C) ? mhpq_pkg::ST_RESP
                                                                : mhpq_pkg::ST_INS_CHK;
                        mhpq_pkg::REQ_EXTRACT:
                            state_next = (count_reg == '0) ? mhpq_pkg::ST_RESP
                                                           : mhpq_pkg::ST_EXT_LD;
                        default:
                            state_next = mhpq_pkg::ST_RESP;
                    endcase
                end
            end
            mhpq_pkg::ST_INS_CHK:
                state_next = (pos_reg == ONE_C) ? mhpq_pkg::ST_RESP : mhpq_pkg::ST_INS_CMP;
            mhpq_pkg::ST_INS_CMP:
                state_next = (ent_reg.key < mem_rdata_a.key) ? mhpq_pkg::ST_INS_CHK
                                                             : mhpq_pkg::ST_RESP;
            mhpq_pkg::ST_EXT_LD:
                state_next = mhpq_pkg::ST_EXT_CHK;
            mhpq_pkg::ST_EXT_CHK:
                state_next = (child_pos > count_x) ? mhpq_pkg::ST_RESP
                                                   : mhpq_pkg::ST_EXT_CMP;
            mhpq_pkg::ST_EXT_CMP:
                state_next = (child_ent.key < ent_reg.key) ? mhpq_pkg::ST_EXT_CHK
                                                           : mhpq_pkg::ST_RESP;
            mhpq_pkg::ST_RESP:
                if (res_take) begin
                    state_next = mhpq_pkg::ST_IDLE;
                end
            default:
                state_next = mhpq_pkg::ST_IDLE;
        endcase
    end

    // datapath and store access
    always_comb begin
        count_next  = count_reg;
        pos_next    = pos_reg;
        ent_next    = ent_reg;
        stat_next   = stat_reg;
        out_next    = out_reg;
        mem_we      = 1'b0;
        mem_waddr   = pos_m1[AW-1:0];
        mem_wdata   = ent_reg;
        mem_raddr_a = '0;
        mem_raddr_b = AW'(count_reg - ONE_C);
        unique case (state_reg)
            mhpq_pkg::ST_IDLE: begin
                // root and last entry are read here for a possible extract
                if (accept) begin
                    stat_next = mhpq_pkg::STAT_OK;
                    out_next  = '0;
                    unique case (req_type)
                        mhpq_pkg::REQ_INSERT: begin
                            if (count_reg >= DEPTH_C) begin
                                stat_next = mhpq_pkg::STAT_FULL;
                            end else begin
                                count_next = count_reg + ONE_C;
                                pos_next   = count_reg + ONE_C;
                                ent_next   = req_ent;
                            end
                        end
                        mhpq_pkg::REQ_EXTRACT: begin
                            if (count_reg == '0) begin
                                stat_next = mhpq_pkg::STAT_EMPTY;
                            end else begin
                                count_next = count_reg - ONE_C;
                                pos_next   = ONE_C;
                            end
                        end
                        mhpq_pkg::REQ_CLEAR: begin
                            count_next = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            mhpq_pkg::ST_INS_CHK: begin
                mem_raddr_a = AW'(up_pos - ONE_C);
                if (pos_reg == ONE_C) begin
                    mem_we = 1'b1;
                end
            end
            mhpq_pkg::ST_INS_CMP: begin
                mem_we = 1'b1;
                if (ent_reg.key < mem_rdata_a.key) begin
                    mem_wdata = mem_rdata_a;   // parent moves down
                    pos_next  = up_pos;
                end
            end
            mhpq_pkg::ST_EXT_LD: begin
                out_next = mem_rdata_a;
                ent_next = mem_rdata_b;
            end
            mhpq_pkg::ST_EXT_CHK: begin
                mem_raddr_a = AW'(child_pos - 1'b1);
                mem_raddr_b = AW'(child_pos);
                if (child_pos > count_x) begin
                    mem_we = 1'b1;
                end
            end
            mhpq_pkg::ST_EXT_CMP: begin
                mem_we = 1'b1;
                if (child_ent.key < ent_reg.key) begin
                    mem_wdata = child_ent;     // child moves up
                    pos_next  = child_sel;
                end
            end
            mhpq_pkg::ST_RESP: begin
            end
            default: begin
            end
        endcase
    end

    assign req_ready   = (state_reg == mhpq_pkg::ST_IDLE);
    assign res_valid   = (state_reg == mhpq_pkg::ST_RESP);
    assign res.status  = stat_reg;
    assign res.count   = count_wide[10:0];
    assign res.ent     = out_reg;

endmodule

// File: rtl/min_heap_priority_queue.sv
// Top level of the binary min-heap priority queue: stream ports, result
// register, sequencer (mhpq_ctrl) and entry store (mhpq_mem). Uses mhpq_pkg.
`timescale 1ns / 1ps
//
// Channel   Dir  Ports                         Fields (low bit first)
// request   in   s_tvalid s_tready s_tuser     req_type
//                s_tdata                       key, item_index, parent_index, parent_trace
// result    out  m_tvalid m_tready m_tuser     status
//                m_tdata                       count, min_key, out_item, out_parent, out_trace
//
// One request in flight; each heap level costs a store read plus a compare
// and write-back. Clear, the unused code, a full insert and an empty extract
// go straight to the result; insert sifts the new entry up from the last
// position, extract loads root and last entry and sifts down from the root.
// aresetn (synchronous) empties the queue. A result waits in the output
// register while the next request runs; a second finished result stalls the
// sequencer until m_tready drains the first.

module min_heap_priority_queue #(
    parameter int HEAP_DEPTH = mhpq_pkg::HEAP_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [mhpq_pkg::S_TUSER_W-1:0] s_tuser,   // [1:0] req_type
    // [31:0] key, [63:32] item_index, [95:64] parent_index, [127:96] parent_trace
    input  logic [mhpq_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [mhpq_pkg::M_TUSER_W-1:0] m_tuser,   // [1:0] status
    // [10:0] count, [42:11] min_key, [74:43] out_item, [106:75] out_parent,
    // [138:107] out_trace, [143:139] zero
    output logic [mhpq_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int AW = $clog2(HEAP_DEPTH);
    localparam int CW = $clog2(HEAP_DEPTH + 1);

    mhpq_pkg::mhpq_entry_t  req_ent;
    mhpq_pkg::mhpq_req_t    req_type;
    mhpq_pkg::mhpq_result_t res;
    logic                   res_valid;
    logic                   res_take;

    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    mhpq_pkg::mhpq_entry_t  mem_wdata;
    logic [AW-1:0]          mem_raddr_a;
    logic [AW-1:0]          mem_raddr_b;
    mhpq_pkg::mhpq_entry_t  mem_rdata_a;
    mhpq_pkg::mhpq_entry_t  mem_rdata_b;

    // output register
    logic                   m_valid_reg, m_valid_next;
    mhpq_pkg::mhpq_result_t m_res_reg, m_res_next;

    assign req_type       = mhpq_pkg::mhpq_req_t'(s_tuser[1:0]);
    assign req_ent.key    = s_tdata[31:0];
    assign req_ent.item   = s_tdata[63:32];
    assign req_ent.parent = s_tdata[95:64];
    assign req_ent.trace  = s_tdata[127:96];

    // result moves over when the output register is empty or being drained
    assign res_take = res_valid && (!m_valid_reg || m_tready);

    always_comb begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (res_take) begin
            m_valid_next = 1'b1;
            m_res_next   = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_res_reg <= m_res_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_res_reg.status;
    assign m_tdata  = {5'b0, m_res_reg.ent.trace, m_res_reg.ent.parent,
                       m_res_reg.ent.item, m_res_reg.ent.key, m_res_reg.count};

    mhpq_ctrl #(
        .HEAP_DEPTH (HEAP_DEPTH),
        .AW         (AW),
        .CW         (CW)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .req_valid   (s_tvalid),
        .req_ready   (s_tready),
        .req_type    (req_type),
        .req_ent     (req_ent),
        .res_valid   (res_valid),
        .res_take    (res_take),
        .res         (res),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_raddr_a (mem_raddr_a),
        .mem_raddr_b (mem_raddr_b),
        .mem_rdata_a (mem_rdata_a),
        .mem_rdata_b (mem_rdata_b)
    );

    mhpq_mem #(
        .DEPTH (HEAP_DEPTH),
        .AW    (AW)
    ) u_mem (
        .aclk    (aclk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .raddr_a (mem_raddr_a),
        .raddr_b (mem_raddr_b),
        .rdata_a (mem_rdata_a),
        .rdata_b (mem_rdata_b)
    );

endmodule
